### design/i2cra_pkg.sv
// Shared types, segment table and helper functions for the I2C register-access master.
`timescale 1ns / 1ps

package i2cra_pkg;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd98;
  localparam logic [3:0] WRITE_LAST_SEG = 4'd7;
  localparam logic [3:0] READ_LAST_SEG  = 4'd10;

  // Byte selectors for transmit segments.
  localparam logic [1:0] TX_ADDR_W = 2'd0;
  localparam logic [1:0] TX_REG    = 2'd1;
  localparam logic [1:0] TX_VALUE  = 2'd2;
  localparam logic [1:0] TX_ADDR_R = 2'd3;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_TX,
    KIND_ACK,
    KIND_RX,
    KIND_NACK,
    KIND_STOP
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t   kind;
    logic [4:0]  len;
    logic [1:0]  arg;
  } seg_t;

  typedef struct packed {
    logic       start_request;
    logic       cmd;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic [2:0] nack_mask;
  } res_t;

  function automatic seg_t seg_lookup(input logic rd, input logic [3:0] idx);
    seg_t s;
    s = '{kind: KIND_STOP, len: 5'd4, arg: 2'd0};
    if (rd) begin
      case (idx)
        4'd0:    s = '{kind: KIND_START, len: 5'd4,  arg: 2'd0};
        4'd1:    s = '{kind: KIND_TX,    len: 5'd24, arg: TX_ADDR_W};
        4'd2:    s = '{kind: KIND_ACK,   len: 5'd4,  arg: 2'd0};
        4'd3:    s = '{kind: KIND_TX,    len: 5'd24, arg: TX_REG};
        4'd4:    s = '{kind: KIND_ACK,   len: 5'd4,  arg: 2'd1};
        4'd5:    s = '{kind: KIND_START, len: 5'd4,  arg: 2'd0};
        4'd6:    s = '{kind: KIND_TX,    len: 5'd24, arg: TX_ADDR_R};
        4'd7:    s = '{kind: KIND_ACK,   len: 5'd4,  arg: 2'd2};
        4'd8:    s = '{kind: KIND_RX,    len: 5'd25, arg: 2'd0};
        4'd9:    s = '{kind: KIND_NACK,  len: 5'd3,  arg: 2'd0};
        default: s = '{kind: KIND_STOP,  len: 5'd4,  arg: 2'd0};
      endcase
    end else begin
      case (idx)
        4'd0:    s = '{kind: KIND_START, len: 5'd4,  arg: 2'd0};
        4'd1:    s = '{kind: KIND_TX,    len: 5'd24, arg: TX_ADDR_W};
        4'd2:    s = '{kind: KIND_ACK,   len: 5'd4,  arg: 2'd0};
        4'd3:    s = '{kind: KIND_TX,    len: 5'd24, arg: TX_REG};
        4'd4:    s = '{kind: KIND_ACK,   len: 5'd4,  arg: 2'd1};
        4'd5:    s = '{kind: KIND_TX,    len: 5'd24, arg: TX_VALUE};
        4'd6:    s = '{kind: KIND_ACK,   len: 5'd4,  arg: 2'd2};
        default: s = '{kind: KIND_STOP,  len: 5'd4,  arg: 2'd0};
      endcase
    end
    return s;
  endfunction

  // Quotient by three for values below 32: multiply by 11/32.
  function automatic logic [3:0] div3(input logic [4:0] v);
    logic [9:0] p;
    p = {5'd0, v} * 10'd11;
    return p[8:5];
  endfunction

  function automatic logic [1:0] mod3(input logic [4:0] v);
    logic [3:0] q;
    logic [5:0] r;
    q = div3(v);
    r = {1'b0, v} - ({2'd0, q} * 6'd3);
    return r[1:0];
  endfunction

endpackage

### design/i2c_register_access_master.sv
// I2C register-access master: request register, phase sequencer and result register.
//
// Each request on the in_ channel is one bus phase tick; it produces exactly one
// result on the out_ channel carrying the SCL/SDA pin levels, the SDA drive enable,
// busy and done flags, the last received byte and the acknowledge error mask.
// A tick with in_start_request high while idle starts a register write
// (in_cmd 0, 92 ticks) or a register read (in_cmd 1, 124 ticks); other fields
// of a start tick are latched then, and ignored while busy.
// The user writes the target address through cfg_wr_en / cfg_wr_data only while
// idle; the block does not enforce this. Throughput: one request per cycle while
// in_stall is low; the request register and the result register each hold one
// entry, so a new request is taken while a result waits. When out_stall is high
// the result holds, the request register fills, and then in_stall rises until the
// result is taken. Reset (synchronous, rst_n low) empties both registers, returns
// the sequencer to idle with SCL and SDA released, and loads the target address 98.
`timescale 1ns / 1ps

module i2c_register_access_master (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_start_request,
  input  logic       in_cmd,
  input  logic [7:0] in_register_address,
  input  logic [7:0] in_write_value,
  input  logic       in_sda_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_sda_drive,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_value,
  output logic [2:0] out_nack_mask
);

  logic            s1_valid_r, s1_valid_nxt;
  i2cra_pkg::req_t s1_req_r;
  logic            out_valid_r, out_valid_nxt;
  i2cra_pkg::res_t out_res_r;
  i2cra_pkg::res_t step_res;
  logic            out_load;
  logic            in_take;

  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= '{start_request:    in_start_request,
                    cmd:              in_cmd,
                    register_address: in_register_address,
                    write_value:      in_write_value,
                    sda_sample:       in_sda_sample};
    end
    if (out_load) begin
      out_res_r <= step_res;
    end
  end

  i2cra_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (out_load),
    .req         (s1_req_r),
    .res         (step_res)
  );

  assign out_valid      = out_valid_r;
  assign out_scl_level  = out_res_r.scl_level;
  assign out_sda_level  = out_res_r.sda_level;
  assign out_sda_drive  = out_res_r.sda_drive;
  assign out_busy_res   = out_res_r.busy_res;
  assign out_done_res   = out_res_r.done_res;
  assign out_read_value = out_res_r.read_value;
  assign out_nack_mask  = out_res_r.nack_mask;

  // An empty result register always lets the request register drain.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("request stalled while result register is empty");

  // A finished transaction is never reported as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> !out_res_r.busy_res)
    else $error("done reported together with busy");

  // SDA is released whenever the master is idle and not finishing a stop.
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.busy_res && !out_res_r.done_res |-> !out_res_r.sda_drive)
    else $error("SDA driven while idle");

endmodule

### design/i2cra_step.sv
// Bus phase sequencer: transaction state and the pin action of one request.
`timescale 1ns / 1ps

module i2cra_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic              step_en,
  input  i2cra_pkg::req_t   req,
  output i2cra_pkg::res_t   res
);

  logic [6:0] dev_addr_r;
  logic       busy_r,    busy_nxt;
  logic [3:0] seg_idx_r, seg_idx_nxt;
  logic [4:0] off_r,     off_nxt;
  logic [7:0] shift_r,   shift_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] reg_r,     reg_nxt;
  logic [7:0] val_r,     val_nxt;
  logic [7:0] rcv_r,     rcv_nxt;
  logic [2:0] err_r,     err_nxt;
  logic       scl_r,     scl_nxt;
  logic       sda_r,     sda_nxt;

  i2cra_pkg::seg_t seg;
  logic       active;
  logic       drive;
  logic       done;
  logic [3:0] seg_idx;
  logic [4:0] off;
  logic [4:0] rx_off;
  logic [3:0] rx_bit;
  logic [1:0] sub;
  logic [1:0] rx_sub;
  logic [7:0] tx_byte;
  logic [7:0] out_byte;
  logic [7:0] rx_shift;
  logic [3:0] last_seg;

  always_comb begin
    is_read_nxt = is_read_r;
    reg_nxt     = reg_r;
    val_nxt     = val_r;
    err_nxt     = err_r;
    shift_nxt   = shift_r;
    seg_idx     = seg_idx_r;
    off         = off_r;
    if (!busy_r && req.start_request) begin
      is_read_nxt = req.cmd;
      reg_nxt     = req.register_address;
      val_nxt     = req.write_value;
      err_nxt     = 3'd0;
      shift_nxt   = 8'd0;
      seg_idx     = 4'd0;
      off         = 5'd0;
    end
    active   = busy_r || req.start_request;
    seg      = i2cra_pkg::seg_lookup(is_read_nxt, seg_idx);
    last_seg = is_read_nxt ? i2cra_pkg::READ_LAST_SEG : i2cra_pkg::WRITE_LAST_SEG;
    sub      = i2cra_pkg::mod3(off);
    rx_off   = off - 5'd1;
    rx_bit   = i2cra_pkg::div3(rx_off);
    rx_sub   = i2cra_pkg::mod3(rx_off);
    rx_shift = {shift_nxt[6:0], req.sda_sample};

    case (seg.arg)
      i2cra_pkg::TX_ADDR_W: tx_byte = {dev_addr_r, 1'b0};
      i2cra_pkg::TX_REG:    tx_byte = reg_nxt;
      i2cra_pkg::TX_VALUE:  tx_byte = val_nxt;
      default:              tx_byte = {dev_addr_r, 1'b1};
    endcase
    out_byte = (off == 5'd0) ? tx_byte : shift_nxt;

    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rcv_nxt     = rcv_r;
    drive       = 1'b0;
    done        = 1'b0;
    busy_nxt    = busy_r;
    seg_idx_nxt = seg_idx_r;
    off_nxt     = off_r;

    if (active) begin
      case (seg.kind)
        i2cra_pkg::KIND_START: begin
          drive = 1'b1;
          case (off[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        i2cra_pkg::KIND_TX: begin
          drive = 1'b1;
          case (sub)
            2'd0: begin
              sda_nxt   = out_byte[7];
              shift_nxt = {out_byte[6:0], 1'b0};
            end
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        i2cra_pkg::KIND_ACK: begin
          case (off[1:0])
            2'd0: sda_nxt = 1'b1;
            2'd1: scl_nxt = 1'b1;
            2'd2: begin
              if (req.sda_sample) begin
                err_nxt = err_nxt | (3'b001 << seg.arg);
              end
            end
            default: scl_nxt = 1'b0;
          endcase
        end
        i2cra_pkg::KIND_RX: begin
          if (off == 5'd0) begin
            sda_nxt   = 1'b1;
            shift_nxt = 8'd0;
          end else begin
            case (rx_sub)
              2'd0: scl_nxt = 1'b1;
              2'd1: begin
                shift_nxt = rx_shift;
                if (rx_bit == 4'd7) begin
                  rcv_nxt = rx_shift;
                end
              end
              default: scl_nxt = 1'b0;
            endcase
          end
        end
        i2cra_pkg::KIND_NACK: begin
          drive = 1'b1;
          case (off[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        default: begin
          drive = 1'b1;
          case (off[1:0])
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b0;
            2'd2:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
      endcase

      if (off == seg.len - 5'd1) begin
        off_nxt = 5'd0;
        if (seg_idx == last_seg) begin
          busy_nxt    = 1'b0;
          done        = 1'b1;
          seg_idx_nxt = 4'd0;
        end else begin
          busy_nxt    = 1'b1;
          seg_idx_nxt = seg_idx + 4'd1;
        end
      end else begin
        busy_nxt    = 1'b1;
        seg_idx_nxt = seg_idx;
        off_nxt     = off + 5'd1;
      end
    end

    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.sda_drive  = drive;
    res.busy_res   = busy_nxt;
    res.done_res   = done;
    res.read_value = rcv_nxt;
    res.nack_mask  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cra_pkg::DEV_ADDR_RESET;
    end else if (cfg_wr_en) begin
      dev_addr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      seg_idx_r <= 4'd0;
      off_r     <= 5'd0;
      shift_r   <= 8'd0;
      is_read_r <= 1'b0;
      reg_r     <= 8'd0;
      val_r     <= 8'd0;
      rcv_r     <= 8'd0;
      err_r     <= 3'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else if (step_en) begin
      busy_r    <= busy_nxt;
      seg_idx_r <= seg_idx_nxt;
      off_r     <= off_nxt;
      shift_r   <= shift_nxt;
      is_read_r <= is_read_nxt;
      reg_r     <= reg_nxt;
      val_r     <= val_nxt;
      rcv_r     <= rcv_nxt;
      err_r     <= err_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

endmodule

### bench/i2c_register_access_master_tb.sv
// Self-checking testbench for the I2C register-access master, driven one bus phase per request.
`timescale 1ns / 1ps

module i2c_register_access_master_tb;

  localparam int WRITE_TICKS = 92;
  localparam int READ_TICKS  = 124;
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_UNTIL = 1500;
  localparam int STEADY_UNTIL = 1900;
  localparam int REQ_BITS = $bits(i2cra_pkg::req_t);

  typedef struct packed {
    i2cra_pkg::seg_kind_t kind;
    logic [4:0]           off;
    logic [1:0]           sel;
  } slot_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [6:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       in_start_request;
  logic       in_cmd;
  logic [7:0] in_register_address;
  logic [7:0] in_write_value;
  logic       in_sda_sample;
  logic       out_valid;
  logic       out_stall;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_sda_drive;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_read_value;
  logic [2:0] out_nack_mask;

  // Bus model state.
  logic [6:0] target_addr = i2cra_pkg::DEV_ADDR_RESET;
  int         bus_phase = 0;
  logic       rd_latched = 1'b0;
  logic [7:0] reg_latched = 8'd0;
  logic [7:0] val_latched = 8'd0;
  logic [7:0] shift_reg = 8'd0;
  logic [7:0] rx_byte = 8'd0;
  logic [2:0] nack_errs = 3'd0;
  logic       scl_q = 1'b1;
  logic       sda_q = 1'b1;

  i2cra_pkg::res_t expected_pins[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   writes_done = 0;
  int   reads_done = 0;
  int   address_writes = 0;
  int   gap_pct = 0;

  i2c_register_access_master dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_start_request    (in_start_request),
    .in_cmd              (in_cmd),
    .in_register_address (in_register_address),
    .in_write_value      (in_write_value),
    .in_sda_sample       (in_sda_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_scl_level       (out_scl_level),
    .out_sda_level       (out_sda_level),
    .out_sda_drive       (out_sda_drive),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_read_value      (out_read_value),
    .out_nack_mask       (out_nack_mask)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Maps a step number of the current transaction to its bus segment and offset.
  function automatic slot_t locate_step(input logic rd, input int n);
    slot_t s;
    s.sel = 2'd0;
    if (n < 4) begin
      s.kind = i2cra_pkg::KIND_START; s.off = 5'(n);
    end else if (n < 28) begin
      s.kind = i2cra_pkg::KIND_TX; s.off = 5'(n - 4); s.sel = i2cra_pkg::TX_ADDR_W;
    end else if (n < 32) begin
      s.kind = i2cra_pkg::KIND_ACK; s.off = 5'(n - 28); s.sel = 2'd0;
    end else if (n < 56) begin
      s.kind = i2cra_pkg::KIND_TX; s.off = 5'(n - 32); s.sel = i2cra_pkg::TX_REG;
    end else if (n < 60) begin
      s.kind = i2cra_pkg::KIND_ACK; s.off = 5'(n - 56); s.sel = 2'd1;
    end else if (!rd) begin
      if (n < 84) begin
        s.kind = i2cra_pkg::KIND_TX; s.off = 5'(n - 60); s.sel = i2cra_pkg::TX_VALUE;
      end else if (n < 88) begin
        s.kind = i2cra_pkg::KIND_ACK; s.off = 5'(n - 84); s.sel = 2'd2;
      end else begin
        s.kind = i2cra_pkg::KIND_STOP; s.off = 5'(n - 88);
      end
    end else if (n < 64) begin
      s.kind = i2cra_pkg::KIND_START; s.off = 5'(n - 60);
    end else if (n < 88) begin
      s.kind = i2cra_pkg::KIND_TX; s.off = 5'(n - 64); s.sel = i2cra_pkg::TX_ADDR_R;
    end else if (n < 92) begin
      s.kind = i2cra_pkg::KIND_ACK; s.off = 5'(n - 88); s.sel = 2'd2;
    end else if (n < 117) begin
      s.kind = i2cra_pkg::KIND_RX; s.off = 5'(n - 92);
    end else if (n < 120) begin
      s.kind = i2cra_pkg::KIND_NACK; s.off = 5'(n - 117);
    end else begin
      s.kind = i2cra_pkg::KIND_STOP; s.off = 5'(n - 120);
    end
    return s;
  endfunction

  // Applies one phase tick to the bus model and returns the pin state it leads to.
  function automatic i2cra_pkg::res_t advance_bus(input i2cra_pkg::req_t r);
    i2cra_pkg::res_t o;
    slot_t s;
    int    n;
    int    k;
    logic  active;
    logic  drives;
    logic  finished;
    active = 1'b1;
    drives = 1'b0;
    finished = 1'b0;
    n = bus_phase;
    if (bus_phase == 0 && r.start_request) begin
      rd_latched = r.cmd;
      reg_latched = r.register_address;
      val_latched = r.write_value;
      nack_errs = 3'd0;
      shift_reg = 8'd0;
      n = 0;
    end else if (bus_phase == 0) begin
      active = 1'b0;
    end
    if (active) begin
      s = locate_step(rd_latched, n);
      k = s.off;
      case (s.kind)
        i2cra_pkg::KIND_START: begin
          drives = 1'b1;
          case (k)
            0: sda_q = 1'b1;
            1: scl_q = 1'b1;
            2: sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
        end
        i2cra_pkg::KIND_TX: begin
          drives = 1'b1;
          if (k % 3 == 0) begin
            if (k == 0) begin
              case (s.sel)
                i2cra_pkg::TX_ADDR_W: shift_reg = {target_addr, 1'b0};
                i2cra_pkg::TX_REG:    shift_reg = reg_latched;
                i2cra_pkg::TX_VALUE:  shift_reg = val_latched;
                default:              shift_reg = {target_addr, 1'b1};
              endcase
            end
            sda_q = shift_reg[7];
            shift_reg = {shift_reg[6:0], 1'b0};
          end else begin
            scl_q = (k % 3 == 1);
          end
        end
        i2cra_pkg::KIND_ACK: begin
          case (k)
            0: sda_q = 1'b1;
            1: scl_q = 1'b1;
            2: if (r.sda_sample) nack_errs[s.sel] = 1'b1;
            default: scl_q = 1'b0;
          endcase
        end
        i2cra_pkg::KIND_RX: begin
          if (k == 0) begin
            sda_q = 1'b1;
            shift_reg = 8'd0;
          end else if ((k - 1) % 3 == 0) begin
            scl_q = 1'b1;
          end else if ((k - 1) % 3 == 1) begin
            shift_reg = {shift_reg[6:0], r.sda_sample};
            if ((k - 1) / 3 == 7) rx_byte = shift_reg;
          end else begin
            scl_q = 1'b0;
          end
        end
        i2cra_pkg::KIND_NACK: begin
          drives = 1'b1;
          case (k)
            0: sda_q = 1'b1;
            1: scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
        end
        default: begin
          drives = 1'b1;
          case (k)
            0: scl_q = 1'b0;
            1: sda_q = 1'b0;
            2: scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
        end
      endcase
      if (n + 1 >= (rd_latched ? READ_TICKS : WRITE_TICKS)) begin
        bus_phase = 0;
        finished = 1'b1;
      end else begin
        bus_phase = n + 1;
      end
    end
    o.scl_level = scl_q;
    o.sda_level = sda_q;
    o.sda_drive = drives;
    o.busy_res = (bus_phase != 0);
    o.done_res = finished;
    o.read_value = rx_byte;
    o.nack_mask = nack_errs;
    return o;
  endfunction

  // Offers one request, with an optional idle burst first, and waits for it to be taken.
  task automatic send_tick(input i2cra_pkg::req_t r);
    int gap;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(16, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_request <= r.start_request;
    in_cmd <= r.cmd;
    in_register_address <= r.register_address;
    in_write_value <= r.write_value;
    in_sda_sample <= r.sda_sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pins.push_back(advance_bus(r));
    items_sent++;
  endtask

  task automatic idle_ticks(input int count);
    i2cra_pkg::req_t r;
    repeat (count) begin
      r = REQ_BITS'($urandom);
      r.start_request = 1'b0;
      send_tick(r);
    end
  endtask

  // One full transaction. Busy ticks carry random request noise that must be ignored;
  // the target answers with nack_plan on the ACK slots and rx_data on a read.
  task automatic run_transaction(input logic rd, input logic [7:0] reg_a,
                                 input logic [7:0] val, input logic [2:0] nack_plan,
                                 input logic [7:0] rx_data);
    i2cra_pkg::req_t r;
    slot_t s;
    int    k;
    r.start_request = 1'b1;
    r.cmd = rd;
    r.register_address = reg_a;
    r.write_value = val;
    r.sda_sample = 1'($urandom_range(1));
    send_tick(r);
    while (bus_phase != 0) begin
      s = locate_step(rd, bus_phase);
      k = s.off;
      r = REQ_BITS'($urandom);
      if (s.kind == i2cra_pkg::KIND_ACK && k == 2)
        r.sda_sample = nack_plan[s.sel];
      else if (s.kind == i2cra_pkg::KIND_RX && k != 0 && (k - 1) % 3 == 1)
        r.sda_sample = rx_data[7 - (k - 1) / 3];
      send_tick(r);
    end
    if (rd) reads_done++;
    else writes_done++;
  endtask

  // Lets every pending result drain before the address register is rewritten.
  task automatic set_target_address(input logic [6:0] addr);
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    target_addr = addr;
    address_writes++;
  endtask

  task automatic test_idle_ticks();
    gap_pct = 0;
    idle_ticks(4);
  endtask

  task automatic test_write_extremes();
    gap_pct = 15;
    run_transaction(1'b0, 8'h00, 8'hFF, 3'b000, 8'h00);
    run_transaction(1'b0, 8'hFF, 8'h00, 3'b111, 8'h00);
  endtask

  task automatic test_read_extremes();
    gap_pct = 15;
    run_transaction(1'b1, 8'hFF, 8'h00, 3'b101, 8'hFF);
    idle_ticks(2);
    run_transaction(1'b1, 8'h00, 8'hFF, 3'b010, 8'h00);
  endtask

  task automatic test_address_config();
    gap_pct = 20;
    set_target_address(7'd127);
    run_transaction(1'b1, 8'h5A, 8'hA5, 3'b000, 8'hA5);
    set_target_address(7'd0);
    run_transaction(1'b0, 8'hA5, 8'h5A, 3'b001, 8'h00);
  endtask

  task automatic random_traffic_until(input int limit, input logic idling);
    logic [2:0] plan;
    int         pick;
    while (items_sent < limit) begin
      if (idling) begin
        pick = $urandom_range(3);
        gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 25 : 40;
      end else begin
        gap_pct = 0;
      end
      // Address changes drain the pipe, so the gap-free stretch leaves them out.
      if (idling && $urandom_range(5) == 0) begin
        pick = $urandom_range(3);
        set_target_address(pick == 0 ? 7'd0 : pick == 1 ? 7'd127 : 7'($urandom_range(127)));
      end
      idle_ticks($urandom_range(3));
      plan[0] = ($urandom_range(3) == 0);
      plan[1] = ($urandom_range(3) == 0);
      plan[2] = ($urandom_range(3) == 0);
      run_transaction(1'($urandom_range(1)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), plan, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic();
    random_traffic_until(RANDOM_UNTIL, 1'b1);
  endtask

  task automatic test_steady_stream();
    random_traffic_until(STEADY_UNTIL, 1'b0);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    i2cra_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pins.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = expected_pins.pop_front();
        compare_field("scl_level", want.scl_level, out_scl_level);
        compare_field("sda_level", want.sda_level, out_sda_level);
        compare_field("sda_drive", want.sda_drive, out_sda_drive);
        compare_field("busy_res", want.busy_res, out_busy_res);
        compare_field("done_res", want.done_res, out_done_res);
        compare_field("read_value", want.read_value, out_read_value);
        compare_field("nack_mask", want.nack_mask, out_nack_mask);
      end
    end
  end

  // The result side holds off in bursts whenever the current idling rate allows it.
  initial begin : result_stall
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct / 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(16, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 7'd0;
    in_valid <= 1'b0;
    in_start_request <= 1'b0;
    in_cmd <= 1'b0;
    in_register_address <= 8'd0;
    in_write_value <= 8'd0;
    in_sda_sample <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_write_extremes();
    test_read_extremes();
    test_address_config();
    test_random_traffic();
    test_steady_stream();

    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Ran %0d phase ticks: %0d register writes and %0d register reads.",
             items_sent, writes_done, reads_done);
    $display("Target address rewritten %0d times; %0d field mismatches seen.",
             address_writes, mismatches);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
design/i2cra_pkg.sv
design/i2cra_step.sv
design/i2c_register_access_master.sv
bench/i2c_register_access_master_tb.sv
